>>> hw/rtl/lbt_pkg.sv
package lbt_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int RANK_W      = $clog2(NUM_ENTRIES);
    localparam int COUNT_W     = $clog2(NUM_ENTRIES + 1);
    localparam int WORD_W      = 64;
    localparam int CAP_W       = 5;
    localparam int OCC_W       = 5;
    localparam int CMP_W       = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

    typedef logic [WORD_W-1:0]      lbt_word_t;
    typedef logic [RANK_W-1:0]      lbt_rank_t;
    typedef logic [COUNT_W-1:0]     lbt_count_t;
    typedef logic [NUM_ENTRIES-1:0] lbt_vec_t;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_PROMOTE = 2'd1,
        REQ_DEMOTE  = 2'd2,
        REQ_EVICT   = 2'd3
    } lbt_req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } lbt_status_t;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_INSERT  = 3'd1,
        OP_PROMOTE = 3'd2,
        OP_DEMOTE  = 3'd3,
        OP_EVICT   = 3'd4
    } lbt_op_t;

    typedef struct packed {
        logic      hit;
        lbt_vec_t  hit_sel;
        lbt_rank_t hit_rank;
        logic      lru_found;
        lbt_vec_t  lru_sel;
        logic      free_found;
        lbt_vec_t  free_sel;
        lbt_word_t handle;
    } lbt_search_t;

    typedef struct packed {
        lbt_op_t   op;
        lbt_word_t key;
        lbt_word_t data;
        lbt_vec_t  hit_sel;
        lbt_rank_t hit_rank;
        lbt_vec_t  free_sel;
        lbt_vec_t  lru_sel;
    } lbt_cmd_t;

endpackage

>>> hw/rtl/lru_block_table_unit.sv
// Fully associative table of up to 16 block numbers with 64-bit handles, kept
// in recency order. A request beat is taken into the input register; from
// there a single pass compares the key against all 16 entries, updates the
// recency ranks and loads the result register, which drives the result beat.
// With the receiver ready, one request beat is accepted every cycle. While a
// result beat is stalled, one more request waits in the input register and
// in_stall stays high until the result is taken. The table is ready after
// reset with no clearing pass. Capacity is written through cfg_write/cfg_data;
// the user must write it only while no request is in flight, as the block itself
// has no check for this. Values above 16 act as 16.
module lru_block_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [63:0] req_key,
    input  logic [63:0] data_ref,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] handle_out,
    output logic [4:0]  occupancy
);

    logic [lbt_pkg::CAP_W-1:0] cap_reg;
    logic [lbt_pkg::CMP_W-1:0] eff_cap;
    logic [lbt_pkg::CMP_W-1:0] count_ext;

    logic                  s1_valid_reg;
    lbt_pkg::lbt_req_t     s1_req_reg;
    lbt_pkg::lbt_word_t    s1_key_reg;
    lbt_pkg::lbt_word_t    s1_data_reg;

    logic                  out_valid_reg;
    lbt_pkg::lbt_status_t  status_reg;
    lbt_pkg::lbt_word_t    handle_reg;
    logic [lbt_pkg::OCC_W-1:0] occ_reg;

    logic                  out_free;
    logic                  in_fire;
    logic                  s1_fire;

    lbt_pkg::lbt_vec_t     valid;
    lbt_pkg::lbt_word_t    keys    [lbt_pkg::NUM_ENTRIES];
    lbt_pkg::lbt_word_t    handles [lbt_pkg::NUM_ENTRIES];
    lbt_pkg::lbt_rank_t    ranks   [lbt_pkg::NUM_ENTRIES];
    lbt_pkg::lbt_count_t   count;
    lbt_pkg::lbt_count_t   count_next;

    lbt_pkg::lbt_search_t  srch;
    lbt_pkg::lbt_cmd_t     cmd;
    lbt_pkg::lbt_op_t      op_c;
    lbt_pkg::lbt_status_t  status_c;
    lbt_pkg::lbt_word_t    handle_c;

    // pipeline handshake: the result register frees when its beat is taken
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;
    assign s1_fire  = s1_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lbt_pkg::CAP_W'(lbt_pkg::NUM_ENTRIES);
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                cap_reg <= cfg_data;
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (out_free)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg  <= lbt_pkg::lbt_req_t'(req_type);
            s1_key_reg  <= req_key;
            s1_data_reg <= data_ref;
        end
        if (s1_fire)
        begin
            status_reg <= status_c;
            handle_reg <= handle_c;
            occ_reg    <= lbt_pkg::OCC_W'(count_next);
        end
    end

    assign eff_cap   = (lbt_pkg::CMP_W'(cap_reg) > lbt_pkg::CMP_W'(lbt_pkg::NUM_ENTRIES))
                     ? lbt_pkg::CMP_W'(lbt_pkg::NUM_ENTRIES) : lbt_pkg::CMP_W'(cap_reg);
    assign count_ext = lbt_pkg::CMP_W'(count);

    lbt_search u_search (
        .req     (s1_req_reg),
        .key     (s1_key_reg),
        .valid   (valid),
        .keys    (keys),
        .handles (handles),
        .ranks   (ranks),
        .count   (count),
        .result  (srch)
    );

    always_comb
    begin
        op_c     = lbt_pkg::OP_NONE;
        status_c = lbt_pkg::ST_MISS;
        handle_c = '0;
        case (s1_req_reg)
            lbt_pkg::REQ_INSERT:
            begin
                // duplicate check wins over the full check
                if (srch.hit)
                    status_c = lbt_pkg::ST_DUP;
                else if (count_ext >= eff_cap || !srch.free_found)
                    status_c = lbt_pkg::ST_FULL;
                else
                begin
                    op_c     = lbt_pkg::OP_INSERT;
                    status_c = lbt_pkg::ST_OK;
                end
            end
            lbt_pkg::REQ_PROMOTE, lbt_pkg::REQ_DEMOTE:
            begin
                if (srch.hit)
                begin
                    op_c     = (s1_req_reg == lbt_pkg::REQ_PROMOTE)
                             ? lbt_pkg::OP_PROMOTE : lbt_pkg::OP_DEMOTE;
                    status_c = lbt_pkg::ST_OK;
                    handle_c = srch.handle;
                end
            end
            lbt_pkg::REQ_EVICT:
            begin
                if (count != '0 && count_ext >= eff_cap && srch.lru_found)
                begin
                    op_c     = lbt_pkg::OP_EVICT;
                    status_c = lbt_pkg::ST_OK;
                    handle_c = srch.handle;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.op       = s1_fire ? op_c : lbt_pkg::OP_NONE;
        cmd.key      = s1_key_reg;
        cmd.data     = s1_data_reg;
        cmd.hit_sel  = srch.hit_sel;
        cmd.hit_rank = srch.hit_rank;
        cmd.free_sel = srch.free_sel;
        cmd.lru_sel  = srch.lru_sel;
    end

    lbt_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .valid      (valid),
        .keys       (keys),
        .handles    (handles),
        .ranks      (ranks),
        .count      (count),
        .count_next (count_next)
    );

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign handle_out = handle_reg;
    assign occupancy  = occ_reg;

    // keys stay unique, so at most one entry matches
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot0(srch.hit_sel))
        else $error("more than one entry matches the key");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lbt_pkg::OP_INSERT) |=>
            (count == lbt_pkg::COUNT_W'($past(count) + 1'b1)))
        else $error("insert did not raise the entry count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lbt_pkg::OP_EVICT) |=>
            (count == lbt_pkg::COUNT_W'($past(count) - 1'b1)))
        else $error("evict did not lower the entry count");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (out_valid && occupancy == lbt_pkg::OCC_W'(count)))
        else $error("result occupancy disagrees with the table");

endmodule

>>> hw/rtl/lbt_search.sv
module lbt_search (
    input  lbt_pkg::lbt_req_t    req,
    input  lbt_pkg::lbt_word_t   key,
    input  lbt_pkg::lbt_vec_t    valid,
    input  lbt_pkg::lbt_word_t   keys    [lbt_pkg::NUM_ENTRIES],
    input  lbt_pkg::lbt_word_t   handles [lbt_pkg::NUM_ENTRIES],
    input  lbt_pkg::lbt_rank_t   ranks   [lbt_pkg::NUM_ENTRIES],
    input  lbt_pkg::lbt_count_t  count,
    output lbt_pkg::lbt_search_t result
);

    lbt_pkg::lbt_vec_t   match;
    lbt_pkg::lbt_vec_t   lru_raw;
    lbt_pkg::lbt_vec_t   free_raw;
    lbt_pkg::lbt_vec_t   sel;
    lbt_pkg::lbt_count_t count_m1;

    assign count_m1 = count - 1'b1;

    always_comb
    begin
        for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
        begin
            match[i]   = valid[i] && (keys[i] == key);
            lru_raw[i] = valid[i] && (ranks[i] == count_m1[lbt_pkg::RANK_W-1:0]);
        end
    end

    assign free_raw = ~valid;

    always_comb
    begin
        result            = '0;
        result.hit        = |match;
        result.hit_sel    = match;
        // isolate the lowest set bit
        result.lru_sel    = lru_raw & (~lru_raw + 1'b1);
        result.lru_found  = |lru_raw;
        result.free_sel   = free_raw & (~free_raw + 1'b1);
        result.free_found = |free_raw;
        sel = (req == lbt_pkg::REQ_EVICT) ? result.lru_sel : match;
        for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
        begin
            if (match[i])
                result.hit_rank = result.hit_rank | ranks[i];
            if (sel[i])
                result.handle = result.handle | handles[i];
        end
    end

endmodule

>>> hw/rtl/lbt_store.sv
module lbt_store (
    input  logic                clk,
    input  logic                rst_n,
    input  lbt_pkg::lbt_cmd_t   cmd,
    output lbt_pkg::lbt_vec_t   valid,
    output lbt_pkg::lbt_word_t  keys    [lbt_pkg::NUM_ENTRIES],
    output lbt_pkg::lbt_word_t  handles [lbt_pkg::NUM_ENTRIES],
    output lbt_pkg::lbt_rank_t  ranks   [lbt_pkg::NUM_ENTRIES],
    output lbt_pkg::lbt_count_t count,
    output lbt_pkg::lbt_count_t count_next
);

    lbt_pkg::lbt_vec_t   valid_reg;
    lbt_pkg::lbt_vec_t   valid_next;
    lbt_pkg::lbt_rank_t  rank_reg  [lbt_pkg::NUM_ENTRIES];
    lbt_pkg::lbt_rank_t  rank_next [lbt_pkg::NUM_ENTRIES];
    lbt_pkg::lbt_word_t  key_reg    [lbt_pkg::NUM_ENTRIES];
    lbt_pkg::lbt_word_t  handle_reg [lbt_pkg::NUM_ENTRIES];
    lbt_pkg::lbt_count_t count_reg;
    lbt_pkg::lbt_count_t count_m1;

    assign count_m1 = count_reg - 1'b1;

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        case (cmd.op)
            lbt_pkg::OP_INSERT:
            begin
                for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
                begin
                    if (valid_reg[i])
                        rank_next[i] = rank_reg[i] + 1'b1;
                    else if (cmd.free_sel[i])
                    begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                end
                count_next = count_reg + 1'b1;
            end
            lbt_pkg::OP_PROMOTE:
            begin
                for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
                begin
                    if (cmd.hit_sel[i])
                        rank_next[i] = '0;
                    else if (valid_reg[i] && rank_reg[i] < cmd.hit_rank)
                        rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            lbt_pkg::OP_DEMOTE:
            begin
                for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
                begin
                    if (cmd.hit_sel[i])
                        rank_next[i] = count_m1[lbt_pkg::RANK_W-1:0];
                    else if (valid_reg[i] && rank_reg[i] > cmd.hit_rank)
                        rank_next[i] = rank_reg[i] - 1'b1;
                end
            end
            lbt_pkg::OP_EVICT:
            begin
                for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
                begin
                    if (cmd.lru_sel[i])
                    begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end
                end
                count_next = count_m1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    // key and handle are only read from valid entries
    always_ff @(posedge clk)
    begin
        if (cmd.op == lbt_pkg::OP_INSERT)
        begin
            for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
            begin
                if (!valid_reg[i] && cmd.free_sel[i])
                begin
                    key_reg[i]    <= cmd.key;
                    handle_reg[i] <= cmd.data;
                end
            end
        end
    end

    assign valid   = valid_reg;
    assign keys    = key_reg;
    assign handles = handle_reg;
    assign ranks   = rank_reg;
    assign count   = count_reg;

endmodule

>>> test/lru_block_table_unit_tb.sv
`timescale 1ns / 1ps

module lru_block_table_unit_tb;

    localparam int POOL_SIZE   = 22;
    localparam int HOLD_CYCLES = 120;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        lbt_pkg::lbt_status_t status;
        lbt_pkg::lbt_word_t   handle;
        logic [4:0]           occ;
    } table_reply_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_write  = 1'b0;
    logic [4:0]  cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type   = '0;
    logic [63:0] req_key    = '0;
    logic [63:0] data_ref   = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [1:0]  status;
    logic [63:0] handle_out;
    logic [4:0]  occupancy;

    // shadow copy of the table
    logic               tbl_valid  [lbt_pkg::NUM_ENTRIES];
    lbt_pkg::lbt_word_t tbl_key    [lbt_pkg::NUM_ENTRIES];
    lbt_pkg::lbt_word_t tbl_handle [lbt_pkg::NUM_ENTRIES];
    int                 tbl_rank   [lbt_pkg::NUM_ENTRIES];
    int                 tbl_count;
    logic [4:0]         tbl_cap;

    table_reply_t       pending_results[$];
    lbt_pkg::lbt_word_t key_pool[POOL_SIZE];

    int send_pct;
    int recv_pct;
    int hold_req;
    int hold_ack;
    int hold_left;
    int err_count;
    int cycle_count;
    int n_sent;
    int n_hit;
    int n_evicted;
    int n_full;
    int n_dup;
    int n_cfg;

    lru_block_table_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .req_key    (req_key),
        .data_ref   (data_ref),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .handle_out (handle_out),
        .occupancy  (occupancy)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request outstanding");
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    err_count++;
                end
                if (handle_out !== want.handle)
                begin
                    $error("handle_out: expected %h, actual %h", want.handle, handle_out);
                    err_count++;
                end
                if (occupancy !== want.occ)
                begin
                    $error("occupancy: expected %0d, actual %0d", want.occ, occupancy);
                    err_count++;
                end
            end
        end
    end

    function automatic int find_entry(lbt_pkg::lbt_word_t key);
        for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic table_reply_t apply_request(lbt_pkg::lbt_req_t req,
                                                   lbt_pkg::lbt_word_t key,
                                                   lbt_pkg::lbt_word_t data);
        table_reply_t res;
        int hit;
        int slot;
        int cap;
        int r;
        res.status = lbt_pkg::ST_MISS;
        res.handle = '0;
        cap = (tbl_cap > lbt_pkg::NUM_ENTRIES) ? lbt_pkg::NUM_ENTRIES : int'(tbl_cap);
        case (req)
            lbt_pkg::REQ_INSERT:
            begin
                if (find_entry(key) >= 0)
                    res.status = lbt_pkg::ST_DUP;
                else if (tbl_count >= cap)
                    res.status = lbt_pkg::ST_FULL;
                else
                begin
                    slot = -1;
                    for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
                    begin
                        if (tbl_valid[i])
                            tbl_rank[i]++;
                        else if (slot < 0)
                            slot = i;
                    end
                    tbl_valid[slot]  = 1'b1;
                    tbl_key[slot]    = key;
                    tbl_handle[slot] = data;
                    tbl_rank[slot]   = 0;
                    tbl_count++;
                    res.status = lbt_pkg::ST_OK;
                end
            end
            lbt_pkg::REQ_PROMOTE, lbt_pkg::REQ_DEMOTE:
            begin
                hit = find_entry(key);
                if (hit >= 0)
                begin
                    r = tbl_rank[hit];
                    for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
                    begin
                        if (!tbl_valid[i] || i == hit)
                            continue;
                        if (req == lbt_pkg::REQ_PROMOTE && tbl_rank[i] < r)
                            tbl_rank[i]++;
                        else if (req == lbt_pkg::REQ_DEMOTE && tbl_rank[i] > r)
                            tbl_rank[i]--;
                    end
                    tbl_rank[hit] = (req == lbt_pkg::REQ_PROMOTE) ? 0 : tbl_count - 1;
                    res.handle = tbl_handle[hit];
                    res.status = lbt_pkg::ST_OK;
                end
            end
            default:
            begin
                // evict only the least recent entry, and only at capacity
                if (tbl_count > 0 && tbl_count >= cap)
                begin
                    for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
                    begin
                        if (tbl_valid[i] && tbl_rank[i] == tbl_count - 1)
                        begin
                            tbl_valid[i] = 1'b0;
                            tbl_rank[i]  = 0;
                            res.handle   = tbl_handle[i];
                            res.status   = lbt_pkg::ST_OK;
                            tbl_count--;
                            break;
                        end
                    end
                end
            end
        endcase
        res.occ = tbl_count[4:0];
        return res;
    endfunction

    task automatic send_req(lbt_pkg::lbt_req_t req, lbt_pkg::lbt_word_t key,
                            lbt_pkg::lbt_word_t data);
        table_reply_t res;
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        req_key   <= key;
        data_ref  <= data;
        do
            @(posedge clk);
        while (in_stall);
        res = apply_request(req, key, data);
        pending_results.insert(pending_results.size(), res);
        n_sent++;
        if (res.status == lbt_pkg::ST_OK && req == lbt_pkg::REQ_EVICT)
            n_evicted++;
        else if (res.status == lbt_pkg::ST_OK && req != lbt_pkg::REQ_INSERT)
            n_hit++;
        else if (res.status == lbt_pkg::ST_FULL)
            n_full++;
        else if (res.status == lbt_pkg::ST_DUP)
            n_dup++;
    endtask

    // stop sending and let every outstanding beat come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_capacity(logic [4:0] cap);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        cfg_write <= 1'b0;
        tbl_cap = cap;
        n_cfg++;
    endtask

    function automatic lbt_pkg::lbt_word_t rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic lbt_pkg::lbt_word_t pick_key(bit want_present);
        int idx;
        if (want_present && tbl_count > 0 && $urandom_range(3) != 0)
        begin
            idx = $urandom_range(lbt_pkg::NUM_ENTRIES - 1);
            while (!tbl_valid[idx])
                idx = (idx + 1) % lbt_pkg::NUM_ENTRIES;
            return tbl_key[idx];
        end
        if ($urandom_range(4) == 0)
            return {$urandom, $urandom};
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic logic [4:0] pick_capacity();
        case ($urandom_range(7))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd2;
            3:       return 5'd16;
            4:       return 5'd16;
            5:       return 5'd31;
            6:       return 5'd8;
            default: return 5'($urandom_range(31));
        endcase
    endfunction

    task automatic send_random_item();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            send_req(lbt_pkg::REQ_INSERT, pick_key(1'b0), rand_word());
        else if (r < 55)
            send_req(lbt_pkg::REQ_PROMOTE, pick_key(1'b1), rand_word());
        else if (r < 75)
            send_req(lbt_pkg::REQ_DEMOTE, pick_key(1'b1), rand_word());
        else
            send_req(lbt_pkg::REQ_EVICT, rand_word(), rand_word());
    endtask

    task automatic test_directed();
        send_pct = 0;
        recv_pct = 0;
        send_req(lbt_pkg::REQ_EVICT,   64'h1234, 64'h5678);
        send_req(lbt_pkg::REQ_PROMOTE, '1, '0);
        send_req(lbt_pkg::REQ_DEMOTE,  '0, '1);
        send_req(lbt_pkg::REQ_INSERT,  '0, '1);
        send_req(lbt_pkg::REQ_INSERT,  '1, '0);
        send_req(lbt_pkg::REQ_INSERT,  '0, 64'h5);
        send_req(lbt_pkg::REQ_PROMOTE, '0, '0);
        send_req(lbt_pkg::REQ_DEMOTE,  '0, '0);
        send_req(lbt_pkg::REQ_EVICT,   '0, '0);
        // shrink to the occupancy and then below it, evicting down
        set_capacity(5'd2);
        send_req(lbt_pkg::REQ_INSERT,  64'h5555_5555_5555_5555, 64'h1);
        send_req(lbt_pkg::REQ_EVICT,   '0, '0);
        send_req(lbt_pkg::REQ_INSERT,  64'haaaa_aaaa_aaaa_aaaa, 64'h8000_0000_0000_0001);
        set_capacity(5'd0);
        send_req(lbt_pkg::REQ_INSERT,  64'h77, 64'h77);
        send_req(lbt_pkg::REQ_EVICT,   '0, '0);
        send_req(lbt_pkg::REQ_EVICT,   '0, '0);
        send_req(lbt_pkg::REQ_EVICT,   '0, '0);
        set_capacity(5'd1);
        send_req(lbt_pkg::REQ_INSERT,  64'h99, '1);
        send_req(lbt_pkg::REQ_INSERT,  64'h9a, '1);
        send_req(lbt_pkg::REQ_PROMOTE, 64'h99, '0);
        send_req(lbt_pkg::REQ_EVICT,   '0, '0);
        set_capacity(5'd31);
        drain();
    endtask

    task automatic test_random(int s_pct, int r_pct, int count);
        send_pct = s_pct;
        recv_pct = r_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 59)
                set_capacity(pick_capacity());
            send_random_item();
        end
        drain();
    endtask

    task automatic test_backpressure();
        set_capacity(5'd16);
        send_pct = 0;
        recv_pct = 0;
        hold_req++;
        // the receiver holds off while beats keep coming, so the input backs up
        for (int i = 0; i < 40; i++)
            send_random_item();
        drain();
    endtask

    task automatic test_sender_pause();
        send_pct = 10;
        recv_pct = 30;
        for (int i = 0; i < 20; i++)
            send_random_item();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 20; i++)
            send_random_item();
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < lbt_pkg::NUM_ENTRIES; i++)
        begin
            tbl_valid[i]  = 1'b0;
            tbl_key[i]    = '0;
            tbl_handle[i] = '0;
            tbl_rank[i]   = 0;
        end
        tbl_count = 0;
        tbl_cap   = 5'd16;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(18, 79, 230);
        test_random(79, 18, 230);
        test_backpressure();
        test_random(0, 0, 200);
        test_sender_pause();

        drain();
        $display("%0d requests: %0d lookup hits, %0d evictions,",
                 n_sent, n_hit, n_evicted);
        $display("%0d full and %0d duplicate rejects, %0d capacity writes, hold-off of %0d cycles",
                 n_full, n_dup, n_cfg, HOLD_CYCLES);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> lru_block_table_unit.f
hw/rtl/lbt_pkg.sv
hw/rtl/lbt_search.sv
hw/rtl/lbt_store.sv
hw/rtl/lru_block_table_unit.sv
test/lru_block_table_unit_tb.sv
